// ===== rtl/crs3_pkg.sv =====
package crs3_pkg;

    localparam int CFG_W      = 31;
    localparam int NUM_MAT    = 9;

    typedef struct packed {
        logic solved;
        logic neg;
    } crs3_tag_t;

endpackage

// ===== rtl/crs3_tri_mul.sv =====
module crs3_tri_mul #(
    parameter int WORD_BITS = 32
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic signed [WORD_BITS-1:0]  a,
    input  logic signed [WORD_BITS-1:0]  b,
    input  logic signed [WORD_BITS-1:0]  c,
    output logic signed [3*WORD_BITS-1:0] prod
);
    localparam int W = WORD_BITS;

    logic signed [2*W-1:0] pair_reg;
    logic signed [W-1:0]   c_reg;
    logic signed [2*W:0]   lo_reg;
    logic signed [2*W-1:0] hi_reg;
    logic signed [3*W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pair_reg <= a * b;
            c_reg    <= c;
            lo_reg   <= $signed({1'b0, pair_reg[W-1:0]}) * c_reg;
            hi_reg   <= $signed(pair_reg[2*W-1:W]) * c_reg;
            prod_reg <= ((3*W)'(hi_reg) <<< W) + (3*W)'(lo_reg);
        end
    end

    assign prod = prod_reg;
endmodule

// ===== rtl/crs3_det.sv =====
module crs3_det #(
    parameter int WORD_BITS = 32
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [WORD_BITS-1:0]    m [crs3_pkg::NUM_MAT],
    output logic signed [3*WORD_BITS+1:0]  det
);
    import crs3_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int DW = 3*W+2;

    logic signed [3*W-1:0] t [6];
    logic signed [DW-1:0]  p_reg;
    logic signed [DW-1:0]  n_reg;
    logic signed [DW-1:0]  det_reg;

    crs3_tri_mul #(.WORD_BITS(W)) u_t0 (.clk(clk), .en(en), .a(m[0]), .b(m[4]), .c(m[8]),
                                         .prod(t[0]));
    crs3_tri_mul #(.WORD_BITS(W)) u_t1 (.clk(clk), .en(en), .a(m[1]), .b(m[5]), .c(m[6]),
                                         .prod(t[1]));
    crs3_tri_mul #(.WORD_BITS(W)) u_t2 (.clk(clk), .en(en), .a(m[2]), .b(m[3]), .c(m[7]),
                                         .prod(t[2]));
    crs3_tri_mul #(.WORD_BITS(W)) u_t3 (.clk(clk), .en(en), .a(m[2]), .b(m[4]), .c(m[6]),
                                         .prod(t[3]));
    crs3_tri_mul #(.WORD_BITS(W)) u_t4 (.clk(clk), .en(en), .a(m[5]), .b(m[7]), .c(m[0]),
                                         .prod(t[4]));
    crs3_tri_mul #(.WORD_BITS(W)) u_t5 (.clk(clk), .en(en), .a(m[8]), .b(m[1]), .c(m[3]),
                                         .prod(t[5]));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg   <= DW'(t[0]) + DW'(t[1]) + DW'(t[2]);
            n_reg   <= DW'(t[3]) + DW'(t[4]) + DW'(t[5]);
            det_reg <= p_reg - n_reg;
        end
    end

    assign det = det_reg;
endmodule

// ===== rtl/crs3_div.sv =====
module crs3_div #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [3*WORD_BITS+1+FRAC_BITS:0]      num,
    input  logic [3*WORD_BITS+1:0]                den,
    input  crs3_pkg::crs3_tag_t                   tag_in,
    output logic [WORD_BITS-2:0]                  quo,
    output logic                                  sat,
    output crs3_pkg::crs3_tag_t                   tag_out
);
    import crs3_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int DW = 3*W+2;
    localparam int RW = DW+W;

    logic [RW-1:0] r_reg   [W];
    logic [DW-1:0] d_reg   [W];
    logic [W-2:0]  q_reg   [W];
    logic          sat_reg [W];
    crs3_tag_t     tag_reg [W];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]   <= RW'(num);
            d_reg[0]   <= den;
            q_reg[0]   <= '0;
            sat_reg[0] <= RW'(num) >= (RW'(den) << (W-1));
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar s = 1; s < W; s++)
    begin : g_stage
        localparam int J = W-1-s;
        logic [RW-1:0] dsh;
        logic          ge;

        assign dsh = RW'(d_reg[s-1]) << J;
        assign ge  = r_reg[s-1] >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s]   <= ge ? (r_reg[s-1] - dsh) : r_reg[s-1];
                d_reg[s]   <= d_reg[s-1];
                q_reg[s]   <= {q_reg[s-1][W-3:0], ge};
                sat_reg[s] <= sat_reg[s-1];
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    assign quo     = q_reg[W-1];
    assign sat     = sat_reg[W-1];
    assign tag_out = tag_reg[W-1];
endmodule

// ===== rtl/cramer_solve_3x3_core.sv =====
// Channel   Direction  Transaction carries
// s_axis    in         tdata: a_r0c0..a_r2c2, rhs_0..rhs_2 (WORD_BITS each)
// m_axis    out        tdata: sol_x, sol_y, sol_z; tuser: solved
// cfg       in         cfg_wdata: min_abs_det, written when cfg_we is high
//
// One transaction enters per cycle while the pipeline is not stalled at m_axis.
// Each transaction passes through the determinant pipeline (five stages), one compare stage,
// the restoring divider (a saturation check, then one stage per quotient bit)
// and the output register.
// A stall at m_axis freezes the whole pipeline; s_axis_tready drops with it.
// Reset clears the valid bits and loads the threshold with 0.1.
module cramer_solve_3x3_core #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // a_r0c0, a_r0c1, a_r0c2, a_r1c0, a_r1c1, a_r1c2, a_r2c0, a_r2c1, a_r2c2,
    // rhs_0, rhs_1, rhs_2, then zero padding.
    input  logic [((12*WORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // sol_x, sol_y, sol_z, then zero padding.
    output logic [((3*WORD_BITS+7)/8)*8-1:0]  m_axis_tdata,
    // solved.
    output logic                         m_axis_tuser,
    input  logic                         cfg_we,
    input  logic [crs3_pkg::CFG_W-1:0]   cfg_wdata
);
    import crs3_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int DW   = 3*W+2;
    localparam int OUTW = ((3*W+7)/8)*8;
    localparam int CW   = ((DW > CFG_W+2*F) ? DW : CFG_W+2*F) + 1;
    localparam int LAT  = W+7;
    localparam logic [CFG_W-1:0] TH_RESET = CFG_W'(((1 << F) + 5) / 10);

    logic                   en;
    logic [LAT-1:0]         v_reg;
    logic [CFG_W-1:0]       th_reg;
    logic signed [W-1:0]    mat [4][NUM_MAT];
    logic signed [DW-1:0]   det [4];
    logic [DW-1:0]          dabs_reg;
    logic [DW-1:0]          nabs_reg [3];
    logic [2:0]             neg_reg;
    logic                   solved_reg;
    logic [W-2:0]           quo [3];
    logic [2:0]             sat;
    crs3_tag_t              tag_out [3];
    logic [W-1:0]           sol_reg [3];
    logic                   sol_ok_reg;

    assign en            = !v_reg[LAT-1] || m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            th_reg <= TH_RESET;
        end
        else
        begin
            if (en)
            begin
                v_reg <= {v_reg[LAT-2:0], s_axis_tvalid};
            end
            if (cfg_we)
            begin
                th_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            for (int i = 0; i < NUM_MAT; i++)
            begin
                mat[k][i] = $signed(s_axis_tdata[i*W +: W]);
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                mat[k+1][r*3+k] = $signed(s_axis_tdata[(NUM_MAT+r)*W +: W]);
            end
        end
    end

    for (genvar k = 0; k < 4; k++)
    begin : g_det
        crs3_det #(.WORD_BITS(W)) u_det (
            .clk (clk),
            .en  (en),
            .m   (mat[k]),
            .det (det[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dabs_reg   <= det[0][DW-1] ? DW'(-det[0]) : DW'(det[0]);
            solved_reg <= (CW'(det[0][DW-1] ? DW'(-det[0]) : DW'(det[0])))
                          > (CW'(th_reg) << (2*F));
            for (int k = 0; k < 3; k++)
            begin
                nabs_reg[k] <= det[k+1][DW-1] ? DW'(-det[k+1]) : DW'(det[k+1]);
                neg_reg[k]  <= det[k+1][DW-1] ^ det[0][DW-1];
            end
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_div
        crs3_tag_t tag_in;

        assign tag_in.solved = solved_reg;
        assign tag_in.neg    = neg_reg[k];

        crs3_div #(.WORD_BITS(W), .FRAC_BITS(F)) u_div (
            .clk     (clk),
            .en      (en),
            .num     ({nabs_reg[k], {F{1'b0}}}),
            .den     (dabs_reg),
            .tag_in  (tag_in),
            .quo     (quo[k]),
            .sat     (sat[k]),
            .tag_out (tag_out[k])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sol_ok_reg <= tag_out[0].solved;
            for (int k = 0; k < 3; k++)
            begin
                if (!tag_out[k].solved)
                begin
                    sol_reg[k] <= '0;
                end
                else if (sat[k])
                begin
                    sol_reg[k] <= tag_out[k].neg ? {1'b1, {(W-1){1'b0}}}
                                                 : {1'b0, {(W-1){1'b1}}};
                end
                else
                begin
                    sol_reg[k] <= tag_out[k].neg ? (W'(0) - {1'b0, quo[k]})
                                                 : {1'b0, quo[k]};
                end
            end
        end
    end

    assign m_axis_tvalid = v_reg[LAT-1];
    assign m_axis_tuser  = sol_ok_reg;
    assign m_axis_tdata  = OUTW'({sol_reg[2], sol_reg[1], sol_reg[0]});
endmodule

// ===== rtl/crs3_check.sv =====
module crs3_check #(
    parameter int WORD_BITS = 32
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [((3*WORD_BITS+7)/8)*8-1:0]    m_axis_tdata,
    input logic                                m_axis_tuser
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Stalled result transaction changed.");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("Unsolved result carries nonzero data.");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("Input ready does not follow the output stall.");
endmodule

bind cramer_solve_3x3_core crs3_check #(.WORD_BITS(WORD_BITS)) u_crs3_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/sv/cramer_solve_3x3_core_tb.sv =====
`timescale 1ns / 1ps

module cramer_solve_3x3_core_tb;

    import crs3_pkg::*;

    localparam int WB        = 32;
    localparam int FB        = 16;
    localparam int IN_W      = ((12 * WB + 7) / 8) * 8;
    localparam int OUT_W     = ((3 * WB + 7) / 8) * 8;
    localparam int LATENCY   = WB + 7;
    localparam int CYCLE_MAX = 400000;
    localparam logic [CFG_W-1:0] THR_RESET = 31'd6554;
    localparam logic signed [WB-1:0] Q_MAX = 32'sh7FFFFFFF;
    localparam logic signed [WB-1:0] Q_MIN = 32'sh80000000;
    localparam logic signed [WB-1:0] ONE   = 32'sh00010000;

    typedef logic signed [255:0] wide_t;
    typedef logic signed [WB-1:0] q_t;

    typedef struct {
        logic solved;
        q_t   x;
        q_t   y;
        q_t   z;
    } solution_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic              m_axis_tuser;
    logic              cfg_we;
    logic [CFG_W-1:0]  cfg_wdata;

    logic [CFG_W-1:0]  min_det_shadow;
    solution_t         expected_solutions[$];
    int                error_count = 0;
    int                cycle_count = 0;
    bit                quiet_mode;

    cramer_solve_3x3_core #(
        .WORD_BITS(WB),
        .FRAC_BITS(FB)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic wide_t sarrus(input wide_t m[9]);
        wide_t pos;
        wide_t neg;
        begin
            pos = m[0] * m[4] * m[8] + m[1] * m[5] * m[6] + m[2] * m[3] * m[7];
            neg = m[2] * m[4] * m[6] + m[5] * m[7] * m[0] + m[8] * m[1] * m[3];
            return pos - neg;
        end
    endfunction

    function automatic q_t saturated_quotient(input wide_t num, input wide_t den);
        wide_t q;
        begin
            q = (num <<< FB) / den;
            if (q > wide_t'(Q_MAX))
                return Q_MAX;
            if (q < wide_t'(Q_MIN))
                return Q_MIN;
            return q_t'(q);
        end
    endfunction

    function automatic solution_t solve_system(input q_t f[12], input logic [CFG_W-1:0] thr);
        wide_t     a[9];
        wide_t     m[9];
        wide_t     det;
        wide_t     mag;
        q_t        sol[3];
        solution_t r;
        begin
            for (int i = 0; i < 9; i++)
                a[i] = wide_t'(f[i]);
            det = sarrus(a);
            mag = (det < 0) ? -det : det;
            r.solved = 1'b0;
            r.x = '0;
            r.y = '0;
            r.z = '0;
            if (mag > (wide_t'({1'b0, thr}) <<< (2 * FB)))
            begin
                for (int k = 0; k < 3; k++)
                begin
                    m = a;
                    for (int i = 0; i < 3; i++)
                        m[i * 3 + k] = wide_t'(f[9 + i]);
                    sol[k] = saturated_quotient(sarrus(m), det);
                end
                r.solved = 1'b1;
                r.x = sol[0];
                r.y = sol[1];
                r.z = sol[2];
            end
            return r;
        end
    endfunction

    task automatic send_system(input q_t f[12]);
        logic [IN_W-1:0] packed_data;
        begin
            packed_data = '0;
            for (int i = 0; i < 12; i++)
                packed_data[i * WB +: WB] = f[i];
            while (!quiet_mode && ($urandom_range(99) < 9))
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= packed_data;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            expected_solutions.insert(expected_solutions.size(),
                                      solve_system(f, min_det_shadow));
        end
    endtask

    task automatic drain_and_write(input logic [CFG_W-1:0] thr);
        begin
            s_axis_tvalid <= 1'b0;
            while (expected_solutions.size() != 0)
                @(posedge clk);
            repeat (LATENCY + 4) @(posedge clk);
            cfg_we    <= 1'b1;
            cfg_wdata <= thr;
            @(posedge clk);
            cfg_we <= 1'b0;
            min_det_shadow = thr;
        end
    endtask

    task automatic send_diag(input q_t d0, input q_t d1, input q_t d2,
                             input q_t b0, input q_t b1, input q_t b2);
        q_t f[12];
        begin
            f = '{d0, 0, 0, 0, d1, 0, 0, 0, d2, b0, b1, b2};
            send_system(f);
        end
    endtask

    task automatic test_directed();
        q_t f[12];
        begin
            send_diag(ONE, ONE, ONE, 32'sh00030000, -32'sh00020000, 32'sh00008000);
            send_diag(ONE, ONE, ONE, Q_MAX, Q_MIN, 0);
            send_diag(1, ONE, ONE, Q_MAX, Q_MIN, 1);
            send_diag(-1, ONE, -ONE, Q_MAX, Q_MIN, -1);
            send_diag(0, 0, 0, Q_MAX, Q_MAX, Q_MAX);
            send_diag(6554, ONE, ONE, ONE, ONE, ONE);
            send_diag(6555, ONE, ONE, ONE, ONE, ONE);
            send_diag(-6554, ONE, ONE, ONE, ONE, ONE);
            send_diag(-6555, ONE, ONE, ONE, ONE, ONE);
            send_diag(-ONE, ONE, ONE, -ONE, -ONE, -ONE);
            send_diag(32'sh00030000, 32'sh00030000, 32'sh00030000, ONE, -ONE, 32'sh7);
            for (int i = 0; i < 12; i++)
                f[i] = Q_MAX;
            send_system(f);
            for (int i = 0; i < 12; i++)
                f[i] = Q_MIN;
            send_system(f);
            f = '{ONE, 2 * ONE, 3 * ONE, 4 * ONE, 5 * ONE, 6 * ONE,
                  7 * ONE, 8 * ONE, 9 * ONE, ONE, ONE, ONE};
            send_system(f);
            f = '{2 * ONE, ONE, -ONE, -3 * ONE, -ONE, 2 * ONE,
                  -2 * ONE, ONE, 2 * ONE, 8 * ONE, -11 * ONE, -3 * ONE};
            send_system(f);
            f = '{Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
                  Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN};
            send_system(f);
            f = '{Q_MIN, 0, 0, 0, Q_MIN, 0, 0, 0, Q_MIN, Q_MAX, Q_MIN, 1};
            send_system(f);
        end
    endtask

    task automatic send_random_system();
        q_t f[12];
        int kind;
        begin
            kind = $urandom_range(99);
            for (int i = 0; i < 12; i++)
            begin
                if (kind < 15)
                    f[i] = $urandom;
                else if (kind < 70)
                    f[i] = $signed($urandom_range(16 * ONE)) - 8 * ONE;
                else
                    f[i] = $signed($urandom_range(512)) - 256;
            end
            if (kind >= 85)
            begin
                // Near-singular system: third row close to the sum of the first two.
                for (int c = 0; c < 3; c++)
                    f[6 + c] = f[c] + f[3 + c] + ($signed($urandom_range(4)) - 2);
            end
            send_system(f);
        end
    endtask

    task automatic test_threshold_edges();
        begin
            drain_and_write('0);
            test_directed();
            drain_and_write({CFG_W{1'b1}});
            test_directed();
            drain_and_write(31'd1);
            test_directed();
        end
    endtask

    task automatic test_random_systems();
        logic [CFG_W-1:0] thr;
        begin
            for (int phase = 0; phase < 5; phase++)
            begin
                case (phase)
                    0: thr = THR_RESET;
                    1: thr = '0;
                    2: thr = CFG_W'($urandom_range(ONE));
                    3: thr = CFG_W'($urandom);
                    default: thr = CFG_W'($urandom_range(64));
                endcase
                drain_and_write(thr);
                for (int n = 0; n < 290; n++)
                begin
                    quiet_mode = (phase == 2) && (n >= 60) && (n < 200);
                    send_random_system();
                end
                quiet_mode = 1'b0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= quiet_mode || ($urandom_range(99) >= 9);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_solutions.size() == 0)
                begin
                    $display("%0t: unexpected result solved=%0b data=%h",
                             $realtime, m_axis_tuser, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    solution_t e;
                    e = expected_solutions.pop_front();
                    if (m_axis_tuser !== e.solved)
                    begin
                        $display("%0t: solved expected %0b actual %0b",
                                 $realtime, e.solved, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata[0 +: WB] !== e.x)
                    begin
                        $display("%0t: sol_x expected %h actual %h",
                                 $realtime, e.x, m_axis_tdata[0 +: WB]);
                        error_count++;
                    end
                    if (m_axis_tdata[WB +: WB] !== e.y)
                    begin
                        $display("%0t: sol_y expected %h actual %h",
                                 $realtime, e.y, m_axis_tdata[WB +: WB]);
                        error_count++;
                    end
                    if (m_axis_tdata[2 * WB +: WB] !== e.z)
                    begin
                        $display("%0t: sol_z expected %h actual %h",
                                 $realtime, e.z, m_axis_tdata[2 * WB +: WB]);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        quiet_mode     = 1'b0;
        min_det_shadow = THR_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_threshold_edges();
        test_random_systems();
        s_axis_tvalid <= 1'b0;
        while (expected_solutions.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
